// ===== hw/rtl/unsorted_max_priority_queue_macros.svh =====
// Assertion macros for the unsorted max priority queue.
// Each macro expects clk and rst in scope at the point of use.
`ifndef UNSORTED_MAX_PRIORITY_QUEUE_MACROS_SVH
`define UNSORTED_MAX_PRIORITY_QUEUE_MACROS_SVH

// Condition holds at every clock edge outside reset
`define UMPQ_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define UMPQ_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define UMPQ_IMPLIES_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/umpq_pkg.sv =====
`default_nettype none

package umpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 7;
  localparam int WORD_W   = 32;

  typedef enum logic [1:0] {
    ACT_ENQUEUE,
    ACT_DEQUEUE,
    ACT_PEEK,
    ACT_MODIFY
  } action_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_NOT_FOUND
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t                    action;
    logic signed [WORD_W-1:0]   data_value;
    logic signed [WORD_W-1:0]   priority_value;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic signed [WORD_W-1:0]   out_data;
    logic signed [WORD_W-1:0]   out_priority;
    logic [ENTRY_W-1:0]         entry_total;
  } rsp_t;

  // One stored entry
  typedef struct packed {
    logic signed [WORD_W-1:0]   data;
    logic signed [WORD_W-1:0]   prio;
  } slot_t;

  // Running best / first-match info passed cell to cell
  typedef struct packed {
    logic                       have;
    logic                       hit;
    logic [IDX_W-1:0]           idx;
    logic signed [WORD_W-1:0]   data;
    logic signed [WORD_W-1:0]   prio;
  } chain_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                       sweep;
    logic                       write;
    logic                       shift;
    logic                       modify;
    logic [CNT_W-1:0]           count;
    logic [IDX_W-1:0]           pos;
    slot_t                      wdata;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/umpq_cell.sv =====
`default_nettype none

module umpq_cell import umpq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] index,
  input  ctl_t             ctl,
  input  chain_t           prev,
  input  slot_t            next_slot,
  output chain_t           link,
  output slot_t            slot
);

  logic   own_valid;
  logic   match;
  logic   own_better;
  chain_t link_next;

  // Local compare against the running best from the left neighbor
  always_comb begin
    own_valid  = CNT_W'(index) < ctl.count;
    match      = own_valid && (slot.data == ctl.wdata.data);
    own_better = own_valid && (!prev.have || ($signed(slot.prio) > $signed(prev.prio)));
    link_next  = prev;
    link_next.have = prev.have | own_valid;
    link_next.hit  = prev.hit | match;
    if (own_better) begin
      link_next.idx  = index;
      link_next.data = slot.data;
      link_next.prio = slot.prio;
    end
  end

  // Chain register, advanced during a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      link <= '0;
    end else if (ctl.sweep) begin
      link <= link_next;
    end
  end

  // Entry storage: append, close gap on removal, priority rewrite
  always_ff @(posedge clk) begin
    if (ctl.write && (CNT_W'(index) == ctl.count)) begin
      slot <= ctl.wdata;
    end else if (ctl.shift && (index >= ctl.pos)) begin
      slot <= next_slot;
    end else if (ctl.modify && match && !prev.hit) begin
      slot.prio <= ctl.wdata.prio;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/umpq_seq.sv =====
`default_nettype none

module umpq_seq import umpq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_ready,
  input  req_t   req,
  output logic   rsp_valid,
  input  logic   rsp_ready,
  output rsp_t   rsp,
  input  chain_t fin,
  output ctl_t   ctl
);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] sweep_cnt;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  req_t             hold;
  rsp_t             rsp_next;
  logic             full;
  logic             empty;

  assign full  = count == CNT_W'(CAPACITY);
  assign empty = count == '0;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.action == ACT_ENQUEUE) ? S_APPLY : S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sweep_cnt == IDX_W'(CAPACITY - 1)) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: state_next = S_DONE;
      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs, cell controls and result
  always_comb begin
    req_ready   = state == S_IDLE;
    rsp_valid   = state == S_DONE;
    ctl         = '0;
    ctl.sweep   = state == S_SWEEP;
    ctl.count   = count;
    ctl.pos     = fin.idx;
    ctl.wdata.data = hold.data_value;
    ctl.wdata.prio = hold.priority_value;
    count_next  = count;
    rsp_next    = '0;
    rsp_next.status = ST_OK;
    if (state == S_APPLY) begin
      case (hold.action)
        ACT_ENQUEUE: begin
          if (full) begin
            rsp_next.status = ST_FULL;
          end else begin
            ctl.write  = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        ACT_DEQUEUE, ACT_PEEK: begin
          if (empty) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            rsp_next.out_data     = fin.data;
            rsp_next.out_priority = fin.prio;
            if (hold.action == ACT_DEQUEUE) begin
              ctl.shift  = 1'b1;
              count_next = count - CNT_W'(1);
            end
          end
        end
        ACT_MODIFY: begin
          if (fin.hit) begin
            ctl.modify = 1'b1;
          end else begin
            rsp_next.status = ST_NOT_FOUND;
          end
        end
        default: rsp_next.status = ST_OK;
      endcase
    end
    rsp_next.entry_total = ENTRY_W'(count_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sweep_cnt <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_SWEEP) begin
        sweep_cnt <= sweep_cnt + IDX_W'(1);
      end else begin
        sweep_cnt <= '0;
      end
    end
  end

  // Request hold and result register
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
    if (state == S_APPLY) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/unsorted_max_priority_queue.sv =====
// Unsorted max priority queue, up to CAPACITY entries kept in insertion order.
// Request channel (req_valid/req_ready/req): action, data_value, priority_value.
// Response channel (rsp_valid/rsp_ready/rsp): status, out_data, out_priority
// and entry_total; exactly one response per request transfer.
// One request is in flight at a time: req_ready is high only while idle, and
// the next request transfer is taken the cycle after the response transfer.
// An enqueue goes from idle straight to the apply step and then to the
// response. Dequeue, peek and modify first sweep along the chain of all
// CAPACITY cells: the running maximum and the first-match flag advance one
// cell per clock, then the apply step performs the removal shift, priority
// rewrite or append in the cells that the broadcast control selects.
// Ties on priority go to the earliest entry; modify hits the first match.
// Reset (rst, synchronous) empties the queue; entry storage is not cleared.
// While the receiver holds rsp_ready low the response stays registered and
// stable and no new request is taken.
`default_nettype none
`include "unsorted_max_priority_queue_macros.svh"

module unsorted_max_priority_queue import umpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  chain_t links [CAPACITY+1];
  slot_t  slots [CAPACITY];
  ctl_t   ctl;

  assign links[0] = '0;

  // Sequencer
  umpq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .fin       (links[CAPACITY]),
    .ctl       (ctl)
  );

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int NXT = (g < CAPACITY - 1) ? g + 1 : g;
    umpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .index     (IDX_W'(g)),
      .ctl       (ctl),
      .prev      (links[g]),
      .next_slot (slots[NXT]),
      .link      (links[g+1]),
      .slot      (slots[g])
    );
  end

  // Checks
  `UMPQ_HOLDS(a_one_side, !(req_ready && rsp_valid), "request taken while response pending")
  `UMPQ_IMPLIES_NEXT(a_no_early_rsp, req_valid && req_ready, !rsp_valid && !req_ready, "response too early")
  `UMPQ_IMPLIES(a_full_count, rsp_valid && (rsp.status == ST_FULL), rsp.entry_total == ENTRY_W'(CAPACITY), "full with short count")
  `UMPQ_IMPLIES(a_empty_count, rsp_valid && (rsp.status == ST_EMPTY), rsp.entry_total == '0, "empty with nonzero count")

endmodule

`default_nettype wire
